// File: sv/fdpn_pkg.sv
// Shared constants, types and helper functions for the flood download node.
package fdpn_pkg;

   // Node geometry and timing
   localparam int FACES           = 6;
   localparam int TICKS_PER_COUNT = 256;
   localparam int STORM_ROUNDS    = 3;
   localparam int MAX_RESULTS     = 20;

   // Field widths
   localparam int OP_W       = 3;
   localparam int FACE_W     = 3;
   localparam int PAGE_W     = 8;
   localparam int CS_W       = 16;
   localparam int ACT_W      = 4;
   localparam int HIST_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int DIV_W = (TICKS_PER_COUNT > 1) ? $clog2(TICKS_PER_COUNT) : 1;
   localparam int STORM_FULL = STORM_ROUNDS * FACES;
   localparam int CNT_W = (MAX_RESULTS > STORM_FULL) ? $clog2(MAX_RESULTS + 1)
                                                     : $clog2(STORM_FULL + 1);

   localparam logic [FACE_W-1:0] NO_FACE = FACE_W'(FACES);

   // Input opcodes
   typedef enum logic [OP_W-1:0] {
      OP_TICK     = 3'd0,
      OP_START    = 3'd1,
      OP_PUSH     = 3'd2,
      OP_SEED     = 3'd3,
      OP_PULL     = 3'd4,
      OP_ACTIVE   = 3'd5,
      OP_FINISHED = 3'd6,
      OP_LETSGO   = 3'd7
   } opcode_type;

   // Result actions
   typedef enum logic [ACT_W-1:0] {
      ACT_NONE      = 4'd0,
      ACT_PULL      = 4'd1,
      ACT_PUSH      = 4'd2,
      ACT_ACTIVE    = 4'd3,
      ACT_FINISHED  = 4'd4,
      ACT_SEED      = 4'd5,
      ACT_BURN      = 4'd6,
      ACT_LETSGO    = 4'd7,
      ACT_EXIT_OK   = 4'd8,
      ACT_EXIT_FAIL = 4'd9
   } action_type;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_AS_ROOT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUILTIN_PAGES    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BUILTIN_CHECKSUM = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_INTERVAL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DONE_TIMEOUT     = 3'd4;

   // Staggered seed order for the six physical faces
   localparam int STAGGER_N = 6;
   localparam logic [FACE_W-1:0] STAGGER [STAGGER_N] =
      '{3'd2, 3'd3, 3'd4, 3'd5, 3'd1, 3'd0};

   // One pending packet or burn result
   typedef struct packed {
      action_type          act;
      logic [FACE_W-1:0]   face;
      logic [PAGE_W-1:0]   page;
   } ev_type;

   // Everything one input item still owes the result channel
   typedef struct packed {
      logic [1:0]          ev_vld;
      ev_type              ev0;
      ev_type              ev1;
      logic                seed_vld;
      logic [FACE_W-1:0]   seed_face;
      logic [PAGE_W-1:0]   seed_pages;
      logic [CS_W-1:0]     seed_cs;
      logic                exit_vld;
      logic                exit_ok;
      logic [CNT_W-1:0]    storm_left;
      logic [FACE_W-1:0]   storm_face;
      logic [FACE_W-1:0]   storm_src;
   } plan_type;

   // Next face in the seed order; faces off the table go to face 0
   function automatic logic [FACE_W-1:0] step_face(input logic [FACE_W-1:0] s);
      logic [FACE_W-1:0] r;
      r = (32'(s) + 1 < FACES) ? FACE_W'(s + 1'b1) : '0;
      if (32'(s) < STAGGER_N) begin
         if (32'(STAGGER[s]) < FACES) r = STAGGER[s];
      end
      return r;
   endfunction

   // Next face of the letsgo storm, skipping the source face
   function automatic logic [FACE_W-1:0] storm_step(input logic [FACE_W-1:0] f,
                                                    input logic [FACE_W-1:0] src);
      logic [FACE_W-1:0] r;
      r = (32'(f) + 1 < FACES) ? FACE_W'(f + 1'b1) : '0;
      if (r == src) r = (32'(r) + 1 < FACES) ? FACE_W'(r + 1'b1) : '0;
      return r;
   endfunction

endpackage

// File: sv/flood_download_protocol_node_top.sv
// Flood download node: event handling, seed/exit scheduling and result sequencing.
//
// Input channel (req_*): one validated event per beat: tick, start, push, seed,
// pull, active, finished or letsgo, with face, page, page count and checksum.
// The node state is updated at the edge that takes the beat, and the results
// the beat causes are held in a plan register, then moved one per cycle into
// the result register (rsp_*) while it is empty or rsp_stall is low;
// rsp_last_of_run marks the final result of a beat. A burn with pull plus seed
// gives three results, an exit with letsgo storm up to twenty. A beat that
// causes no result leaves the plan empty and does not stall the input.
// req_stall rises while the plan still holds results other than the one
// leaving this cycle. While a valid result is stalled, the result register
// and the plan hold, and so does the input side while the plan holds results.
// Configuration (csr_*) is always ready; the user must see that it is written
// only while the node is idle, which the block itself does not enforce. Reset
// (synchronous, active high) clears the node state, the plan and the result
// valid flag, and returns the configuration registers to their defaults.
module flood_download_protocol_node_top (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [fdpn_pkg::OP_W-1:0]       req_opcode,
   input  logic [fdpn_pkg::FACE_W-1:0]     req_face,
   input  logic [fdpn_pkg::PAGE_W-1:0]     req_page,
   input  logic [fdpn_pkg::PAGE_W-1:0]     req_pages,
   input  logic [fdpn_pkg::CS_W-1:0]       req_program_checksum,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [fdpn_pkg::ACT_W-1:0]      rsp_action,
   output logic [fdpn_pkg::FACE_W-1:0]     rsp_out_face,
   output logic [fdpn_pkg::PAGE_W-1:0]     rsp_out_page,
   output logic [fdpn_pkg::PAGE_W-1:0]     rsp_out_pages,
   output logic [fdpn_pkg::CS_W-1:0]       rsp_out_checksum,
   output logic                            rsp_last_of_run,
   // configuration port
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fdpn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fdpn_pkg::CSR_DATA_W-1:0] csr_data
);
   import fdpn_pkg::*;

   // Configuration registers
   logic               start_as_root_ff;
   logic [PAGE_W-1:0]  builtin_pages_ff;
   logic [CS_W-1:0]    builtin_checksum_ff;
   logic [PAGE_W-1:0]  seed_interval_ff;
   logic [PAGE_W-1:0]  done_timeout_ff;

   // Node state
   logic               running_ff,   running_in;
   logic [PAGE_W-1:0]  total_ff,     total_in;
   logic [PAGE_W-1:0]  next_ff,      next_in;
   logic [FACE_W-1:0]  source_ff,    source_in;
   logic [CS_W-1:0]    image_cs_ff,  image_cs_in;
   logic [FACE_W-1:0]  seed_face_ff, seed_face_in;
   logic [HIST_W-1:0]  hist_ff,      hist_in;
   logic [DIV_W-1:0]   tick_div_ff,  tick_div_in;
   logic [PAGE_W-1:0]  seed_cd_ff,   seed_cd_in;
   logic [PAGE_W-1:0]  done_cd_ff,   done_cd_in;

   // Plan of pending results
   plan_type           plan_ff, plan_new, plan_pop;
   logic               plan_pending;
   logic               pop_last;
   logic               out_load;
   logic               pop;
   logic               req_accept;

   // Result register
   logic               rsp_valid_ff;
   action_type         rsp_act_ff,   rsp_act_in;
   logic [FACE_W-1:0]  rsp_face_ff,  rsp_face_in;
   logic [PAGE_W-1:0]  rsp_page_ff,  rsp_page_in;
   logic [PAGE_W-1:0]  rsp_pages_ff, rsp_pages_in;
   logic [CS_W-1:0]    rsp_cs_ff,    rsp_cs_in;
   logic               rsp_last_ff;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_as_root_ff    <= 1'b0;
         builtin_pages_ff    <= PAGE_W'(56);
         builtin_checksum_ff <= '0;
         seed_interval_ff    <= PAGE_W'(2);
         done_timeout_ff     <= PAGE_W'(77);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_AS_ROOT:    start_as_root_ff    <= csr_data[0];
            CSR_BUILTIN_PAGES:    builtin_pages_ff    <= csr_data[PAGE_W-1:0];
            CSR_BUILTIN_CHECKSUM: builtin_checksum_ff <= csr_data[CS_W-1:0];
            CSR_SEED_INTERVAL:    seed_interval_ff    <= csr_data[PAGE_W-1:0];
            CSR_DONE_TIMEOUT:     done_timeout_ff     <= csr_data[PAGE_W-1:0];
            default: ;
         endcase
      end
   end

   // Handle the incoming event, then schedule seed and exit
   always_comb begin
      logic [DIV_W-1:0]  div_nxt;
      logic [FACE_W-1:0] s;
      logic              ok;
      logic [CNT_W-1:0]  n0;
      logic [CNT_W-1:0]  cap;
      logic [CNT_W-1:0]  full;

      running_in   = running_ff;
      total_in     = total_ff;
      next_in      = next_ff;
      source_in    = source_ff;
      image_cs_in  = image_cs_ff;
      seed_face_in = seed_face_ff;
      hist_in      = hist_ff;
      tick_div_in  = tick_div_ff;
      seed_cd_in   = seed_cd_ff;
      done_cd_in   = done_cd_ff;
      plan_new     = '0;
      div_nxt      = '0;
      s            = '0;
      ok           = 1'b0;
      n0           = '0;
      cap          = '0;
      full         = '0;

      priority if (req_opcode == OP_START) begin
         if (start_as_root_ff) begin
            image_cs_in = builtin_checksum_ff;
            total_in    = builtin_pages_ff;
            next_in     = builtin_pages_ff;
         end else begin
            total_in = '0;
            next_in  = '0;
         end
         source_in  = NO_FACE;
         hist_in    = '0;
         seed_cd_in = seed_interval_ff;
         done_cd_in = done_timeout_ff;
         running_in = 1'b1;
      end else if (req_opcode == OP_TICK) begin
         // advance the prescaler, step the countdowns when it wraps to zero
         if (tick_div_ff == '0) div_nxt = DIV_W'(TICKS_PER_COUNT - 1);
         else                   div_nxt = tick_div_ff - 1'b1;
         tick_div_in = div_nxt;
         if (div_nxt == '0) begin
            if (seed_cd_ff != '0) seed_cd_in = seed_cd_ff - 1'b1;
            if (done_cd_ff != '0) done_cd_in = done_cd_ff - 1'b1;
         end
      end else if (running_ff && (32'(req_face) < FACES)) begin
         unique case (req_opcode)
            OP_PUSH: begin
               if ((req_page < total_in) && (req_page == next_in)) begin
                  plan_new.ev0    = '{act: ACT_BURN, face: NO_FACE, page: req_page};
                  plan_new.ev_vld = 2'b01;
                  next_in         = next_in + 1'b1;
                  if (next_in != total_in) begin
                     done_cd_in      = done_timeout_ff;
                     plan_new.ev1    = '{act: ACT_PULL, face: req_face, page: next_in};
                     plan_new.ev_vld = 2'b11;
                  end
               end
            end
            OP_SEED: begin
               if (total_in == '0) begin
                  total_in     = req_pages;
                  image_cs_in  = req_program_checksum;
                  source_in    = req_face;
                  seed_face_in = req_face;
               end
               if (req_face == source_in) begin
                  plan_new.ev_vld = 2'b01;
                  priority if (next_in < total_in) begin
                     plan_new.ev0 = '{act: ACT_PULL, face: req_face, page: next_in};
                  end else if (hist_in != '0) begin
                     plan_new.ev0 = '{act: ACT_ACTIVE, face: req_face, page: '0};
                     hist_in      = {hist_in[HIST_W-2:0], 1'b0};
                  end else begin
                     plan_new.ev0 = '{act: ACT_FINISHED, face: req_face, page: '0};
                  end
                  done_cd_in = done_timeout_ff;
               end
            end
            OP_PULL: begin
               if (req_page < next_in) begin
                  plan_new.ev0    = '{act: ACT_PUSH, face: req_face, page: req_page};
                  plan_new.ev_vld = 2'b01;
                  seed_cd_in      = seed_interval_ff;
                  done_cd_in      = done_timeout_ff;
               end
               hist_in[0] = 1'b1;
            end
            OP_ACTIVE: begin
               hist_in[0] = 1'b1;
               done_cd_in = done_timeout_ff;
            end
            OP_FINISHED: begin
               if (source_ff != NO_FACE) done_cd_in = done_timeout_ff;
            end
            default: begin
               // letsgo from the source ends the run
               if (req_face == source_ff) done_cd_in = '0;
            end
         endcase
      end

      if (running_in) begin
         // seed on the next staggered face that is not the source
         if ((seed_cd_in == '0) && (next_in != '0)) begin
            s = step_face(seed_face_in);
            if (s == source_in) s = step_face(s);
            seed_face_in        = s;
            plan_new.seed_vld   = 1'b1;
            plan_new.seed_face  = s;
            plan_new.seed_pages = total_in;
            plan_new.seed_cs    = image_cs_in;
            seed_cd_in          = seed_interval_ff;
         end
         // exit: storm of letsgo on good image, capped to fit the exit result
         if (done_cd_in == '0) begin
            ok  = (total_in != '0) && (next_in >= total_in);
            n0  = CNT_W'(plan_new.ev_vld[0]) + CNT_W'(plan_new.ev_vld[1])
                + CNT_W'(plan_new.seed_vld);
            cap = CNT_W'(MAX_RESULTS - 1) - n0;
            if (32'(source_in) < FACES) full = CNT_W'(STORM_ROUNDS * (FACES - 1));
            else                        full = CNT_W'(STORM_ROUNDS * FACES);
            plan_new.exit_vld   = 1'b1;
            plan_new.exit_ok    = ok;
            plan_new.storm_left = ok ? ((full < cap) ? full : cap) : '0;
            plan_new.storm_face = (source_in == '0) ? FACE_W'(1) : '0;
            plan_new.storm_src  = source_in;
            running_in          = 1'b0;
         end
      end
   end

   // Pick the head of the plan
   always_comb begin
      plan_pop     = plan_ff;
      rsp_act_in   = ACT_NONE;
      rsp_face_in  = '0;
      rsp_page_in  = '0;
      rsp_pages_in = '0;
      rsp_cs_in    = '0;

      priority if (plan_ff.ev_vld[0]) begin
         rsp_act_in         = plan_ff.ev0.act;
         rsp_face_in        = plan_ff.ev0.face;
         rsp_page_in        = plan_ff.ev0.page;
         plan_pop.ev_vld[0] = 1'b0;
      end else if (plan_ff.ev_vld[1]) begin
         rsp_act_in         = plan_ff.ev1.act;
         rsp_face_in        = plan_ff.ev1.face;
         rsp_page_in        = plan_ff.ev1.page;
         plan_pop.ev_vld[1] = 1'b0;
      end else if (plan_ff.seed_vld) begin
         rsp_act_in        = ACT_SEED;
         rsp_face_in       = plan_ff.seed_face;
         rsp_pages_in      = plan_ff.seed_pages;
         rsp_cs_in         = plan_ff.seed_cs;
         plan_pop.seed_vld = 1'b0;
      end else if (plan_ff.storm_left != '0) begin
         rsp_act_in          = ACT_LETSGO;
         rsp_face_in         = plan_ff.storm_face;
         plan_pop.storm_left = plan_ff.storm_left - 1'b1;
         plan_pop.storm_face = storm_step(plan_ff.storm_face, plan_ff.storm_src);
      end else if (plan_ff.exit_vld) begin
         rsp_act_in        = plan_ff.exit_ok ? ACT_EXIT_OK : ACT_EXIT_FAIL;
         rsp_face_in       = NO_FACE;
         plan_pop.exit_vld = 1'b0;
      end else begin
         plan_pop = plan_ff;
      end
   end

   assign plan_pending = (plan_ff.ev_vld != '0) || plan_ff.seed_vld
                      || (plan_ff.storm_left != '0) || plan_ff.exit_vld;
   assign pop_last     = (plan_pop.ev_vld == '0) && !plan_pop.seed_vld
                      && (plan_pop.storm_left == '0) && !plan_pop.exit_vld;
   assign out_load     = !rsp_valid_ff || !rsp_stall;
   assign pop          = plan_pending && out_load;
   assign req_stall    = plan_pending && !(pop && pop_last);
   assign req_accept   = req_valid && !req_stall;

   // Update node state on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         total_ff     <= '0;
         next_ff      <= '0;
         source_ff    <= NO_FACE;
         image_cs_ff  <= '0;
         seed_face_ff <= '0;
         hist_ff      <= '0;
         tick_div_ff  <= '0;
         seed_cd_ff   <= '0;
         done_cd_ff   <= '0;
      end else if (req_accept) begin
         running_ff   <= running_in;
         total_ff     <= total_in;
         next_ff      <= next_in;
         source_ff    <= source_in;
         image_cs_ff  <= image_cs_in;
         seed_face_ff <= seed_face_in;
         hist_ff      <= hist_in;
         tick_div_ff  <= tick_div_in;
         seed_cd_ff   <= seed_cd_in;
         done_cd_ff   <= done_cd_in;
      end
   end

   // Load a fresh plan on accept, otherwise drop the head as it leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         plan_ff <= '0;
      end else if (req_accept) begin
         plan_ff <= plan_new;
      end else if (pop) begin
         plan_ff <= plan_pop;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_act_ff   <= rsp_act_in;
         rsp_face_ff  <= rsp_face_in;
         rsp_page_ff  <= rsp_page_in;
         rsp_pages_ff <= rsp_pages_in;
         rsp_cs_ff    <= rsp_cs_in;
         rsp_last_ff  <= pop_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = rsp_act_ff;
   assign rsp_out_face     = rsp_face_ff;
   assign rsp_out_page     = rsp_page_ff;
   assign rsp_out_pages    = rsp_pages_ff;
   assign rsp_out_checksum = rsp_cs_ff;
   assign rsp_last_of_run  = rsp_last_ff;

   // A pending plan that is not finishing this cycle must hold the input side
   assert property (@(posedge clock) disable iff (reset)
      (plan_pending && !(pop && pop_last)) |-> req_stall)
      else $error("input taken while results still pending");

   // The run only ends through an exit, which must be queued
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(running_ff)) |-> plan_ff.exit_vld)
      else $error("node stopped without an exit result");

   // A storm only precedes a successful exit
   assert property (@(posedge clock) disable iff (reset)
      (plan_ff.storm_left != '0) |-> (plan_ff.exit_vld && plan_ff.exit_ok))
      else $error("letsgo storm without a good exit");

   // Source face is a real face or none
   assert property (@(posedge clock) disable iff (reset)
      source_ff <= NO_FACE)
      else $error("source face out of range");

endmodule

// File: verif/node_check_pkg.sv
// Scoreboard for the flood download node: predicts every result and checks what comes back.
package node_check_pkg;
   import fdpn_pkg::*;

   // One result beat as the node should send it
   typedef struct packed {
      action_type        act;
      logic [FACE_W-1:0] face;
      logic [PAGE_W-1:0] page;
      logic [PAGE_W-1:0] pages;
      logic [CS_W-1:0]   cs;
      logic              last;
   } node_result_t;

   class node_scoreboard;
      // configuration registers
      logic              root_start;
      logic [PAGE_W-1:0] builtin_pages;
      logic [CS_W-1:0]   builtin_cs;
      logic [7:0]        seed_interval;
      logic [7:0]        done_timeout;
      // node state
      logic              running;
      logic [PAGE_W-1:0] total_pages;
      logic [PAGE_W-1:0] next_page;
      logic [FACE_W-1:0] source_face;
      logic [FACE_W-1:0] seed_face;
      logic [CS_W-1:0]   image_cs;
      logic [HIST_W-1:0] activity;
      logic [DIV_W-1:0]  tick_div;
      logic [7:0]        seed_cd;
      logic [7:0]        done_cd;
      // results owed by accepted beats, oldest first
      node_result_t      owed_results[$];
      node_result_t      beat_results[$];
      int                errors;

      function new();
         root_start    = 1'b0;
         builtin_pages = 8'd56;
         builtin_cs    = '0;
         seed_interval = 8'd2;
         done_timeout  = 8'd77;
         running       = 1'b0;
         total_pages   = '0;
         next_page     = '0;
         source_face   = NO_FACE;
         seed_face     = '0;
         image_cs      = '0;
         activity      = '0;
         tick_div      = '0;
         seed_cd       = '0;
         done_cd       = '0;
         errors        = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_START_AS_ROOT:    root_start    = data[0];
            CSR_BUILTIN_PAGES:    builtin_pages = data[7:0];
            CSR_BUILTIN_CHECKSUM: builtin_cs    = data;
            CSR_SEED_INTERVAL:    seed_interval = data[7:0];
            CSR_DONE_TIMEOUT:     done_timeout  = data[7:0];
            default: ;
         endcase
      endfunction

      // Append one result to the current beat, dropping anything past the cap
      function void add_result(action_type act, logic [FACE_W-1:0] face,
                               logic [PAGE_W-1:0] page, logic [PAGE_W-1:0] pages,
                               logic [CS_W-1:0] cs);
         node_result_t r;
         if (beat_results.size() >= MAX_RESULTS) return;
         r = '{act, face, page, pages, cs, 1'b0};
         beat_results.push_back(r);
      endfunction

      // Advance the node by one accepted input beat and queue what it owes
      function void apply_event(opcode_type op, logic [FACE_W-1:0] face,
                                logic [PAGE_W-1:0] page, logic [PAGE_W-1:0] pages,
                                logic [CS_W-1:0] cs);
         logic [FACE_W-1:0] s;
         node_result_t      r;
         beat_results.delete();
         case (op)
            OP_START: begin
               if (root_start) begin
                  image_cs    = builtin_cs;
                  total_pages = builtin_pages;
                  next_page   = builtin_pages;
               end else begin
                  total_pages = '0;
                  next_page   = '0;
               end
               source_face = NO_FACE;
               activity    = '0;
               seed_cd     = seed_interval;
               done_cd     = done_timeout;
               running     = 1'b1;
            end
            OP_TICK: begin
               // prescaler wraps; both countdowns step once per wrap
               tick_div = (tick_div == 0) ? DIV_W'(TICKS_PER_COUNT - 1) : tick_div - 1'b1;
               if (tick_div == 0) begin
                  if (seed_cd != 0) seed_cd--;
                  if (done_cd != 0) done_cd--;
               end
            end
            default: begin
               if (running && face < FACES) begin
                  case (op)
                     OP_PUSH: begin
                        if (page < total_pages && page == next_page) begin
                           add_result(ACT_BURN, NO_FACE, page, '0, '0);
                           next_page++;
                           if (next_page != total_pages) begin
                              done_cd = done_timeout;
                              add_result(ACT_PULL, face, next_page, '0, '0);
                           end
                        end
                     end
                     OP_SEED: begin
                        // first seed fixes the image and the source face
                        if (total_pages == 0) begin
                           total_pages = pages;
                           image_cs    = cs;
                           source_face = face;
                           seed_face   = face;
                        end
                        if (face == source_face) begin
                           if (next_page < total_pages)
                              add_result(ACT_PULL, face, next_page, '0, '0);
                           else if (activity != 0) begin
                              add_result(ACT_ACTIVE, face, '0, '0, '0);
                              activity = {activity[1:0], 1'b0};
                           end else
                              add_result(ACT_FINISHED, face, '0, '0, '0);
                           done_cd = done_timeout;
                        end
                     end
                     OP_PULL: begin
                        if (page < next_page) begin
                           add_result(ACT_PUSH, face, page, '0, '0);
                           seed_cd = seed_interval;
                           done_cd = done_timeout;
                        end
                        activity[0] = 1'b1;
                     end
                     OP_ACTIVE: begin
                        activity[0] = 1'b1;
                        done_cd     = done_timeout;
                     end
                     OP_FINISHED: if (source_face != NO_FACE) done_cd = done_timeout;
                     OP_LETSGO:   if (face == source_face) done_cd = '0;
                     default: ;
                  endcase
               end
            end
         endcase

         if (running) begin
            // seed on the next face of the staggered order, skipping the source
            if (seed_cd == 0 && next_page > 0) begin
               s = seed_face;
               for (int k = 0; k <= FACES; k++) begin
                  if (s < STAGGER_N && STAGGER[s] < FACES) s = STAGGER[s];
                  else s = (s + 1 < FACES) ? s + 1'b1 : '0;
                  if (s != source_face) break;
               end
               seed_face = s;
               add_result(ACT_SEED, s, '0, total_pages, image_cs);
               seed_cd = seed_interval;
            end
            // exit: storm then success, or failure on an incomplete image
            if (done_cd == 0) begin
               if (total_pages > 0 && next_page >= total_pages) begin
                  for (int t = 0; t < STORM_ROUNDS; t++)
                     for (int f = 0; f < FACES; f++)
                        if (FACE_W'(f) != source_face && beat_results.size() < MAX_RESULTS - 1)
                           add_result(ACT_LETSGO, FACE_W'(f), '0, '0, '0);
                  add_result(ACT_EXIT_OK, NO_FACE, '0, '0, '0);
               end else
                  add_result(ACT_EXIT_FAIL, NO_FACE, '0, '0, '0);
               running = 1'b0;
            end
         end

         // mark the final result of the beat
         if (beat_results.size() > 0) begin
            r      = beat_results.pop_back();
            r.last = 1'b1;
            beat_results.push_back(r);
         end
         foreach (beat_results[i]) owed_results.push_back(beat_results[i]);
      endfunction

      // Compare one result beat against the oldest owed result
      function void check_result(logic [ACT_W-1:0] act, logic [FACE_W-1:0] face,
                                 logic [PAGE_W-1:0] page, logic [PAGE_W-1:0] pages,
                                 logic [CS_W-1:0] cs, logic last);
         node_result_t want;
         if (owed_results.size() == 0) begin
            $error("result beat with nothing owed: action %0d face %0d", act, face);
            errors++;
            return;
         end
         want = owed_results.pop_front();
         if (want.act !== act) begin
            $error("action: expected %0d, got %0d", want.act, act);
            errors++;
         end
         if (want.face !== face) begin
            $error("out_face: expected %0d, got %0d", want.face, face);
            errors++;
         end
         if (want.page !== page) begin
            $error("out_page: expected %0d, got %0d", want.page, page);
            errors++;
         end
         if (want.pages !== pages) begin
            $error("out_pages: expected %0d, got %0d", want.pages, pages);
            errors++;
         end
         if (want.cs !== cs) begin
            $error("out_checksum: expected %0h, got %0h", want.cs, cs);
            errors++;
         end
         if (want.last !== last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, last);
            errors++;
         end
      endfunction
   endclass

endpackage

// File: verif/tb_top.sv
// Top-level testbench: drives the flood download node with directed and random beats.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import fdpn_pkg::*;
   import node_check_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int ITEM_TARGET   = 280;
   localparam int SETTLE_CYCLES = 30;

   logic                  clock                = 1'b0;
   logic                  reset                = 1'b1;
   logic                  req_valid            = 1'b0;
   logic                  req_stall;
   opcode_type            req_opcode           = OP_TICK;
   logic [FACE_W-1:0]     req_face             = '0;
   logic [PAGE_W-1:0]     req_page             = '0;
   logic [PAGE_W-1:0]     req_pages            = '0;
   logic [CS_W-1:0]       req_program_checksum = '0;
   logic                  rsp_valid;
   logic                  rsp_stall            = 1'b0;
   logic [ACT_W-1:0]      rsp_action;
   logic [FACE_W-1:0]     rsp_out_face;
   logic [PAGE_W-1:0]     rsp_out_page;
   logic [PAGE_W-1:0]     rsp_out_pages;
   logic [CS_W-1:0]       rsp_out_checksum;
   logic                  rsp_last_of_run;
   logic                  csr_valid            = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index            = '0;
   logic [CSR_DATA_W-1:0] csr_data             = '0;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int cycles        = 0;
   int items_sent    = 0;

   node_scoreboard flood_sb = new();

   flood_download_protocol_node_top DUT (.*);

   always #2 clock = ~clock;

   // Bound the run
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Stall the result channel at random
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   // Check every result beat taken
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         flood_sb.check_result(rsp_action, rsp_out_face, rsp_out_page, rsp_out_pages,
                               rsp_out_checksum, rsp_last_of_run);
   end

   // Offer one input beat after a random gap and hold it until taken
   task automatic send_event(opcode_type op, logic [FACE_W-1:0] face,
                             logic [PAGE_W-1:0] page, logic [PAGE_W-1:0] pages,
                             logic [CS_W-1:0] cs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid            <= 1'b1;
      req_opcode           <= op;
      req_face             <= face;
      req_page             <= page;
      req_pages            <= pages;
      req_program_checksum <= cs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      flood_sb.apply_event(op, face, page, pages, cs);
      @(negedge clock);
   endtask

   // Ticks carry random payload so the ignored fields still toggle
   task automatic send_ticks(int count);
      repeat (count)
         send_event(OP_TICK, FACE_W'($urandom_range(7)), PAGE_W'($urandom),
                    PAGE_W'($urandom), CS_W'($urandom));
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      flood_sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Drain all owed results, let the node go quiet, then load every register
   task automatic configure_node(logic root, logic [7:0] pages, logic [CS_W-1:0] cs,
                                 logic [7:0] seed_int, logic [7:0] timeout);
      req_valid <= 1'b0;
      while (flood_sb.owed_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write(CSR_START_AS_ROOT, CSR_DATA_W'(root));
      csr_write(CSR_BUILTIN_PAGES, CSR_DATA_W'(pages));
      csr_write(CSR_BUILTIN_CHECKSUM, cs);
      csr_write(CSR_SEED_INTERVAL, CSR_DATA_W'(seed_int));
      csr_write(CSR_DONE_TIMEOUT, CSR_DATA_W'(timeout));
   endtask

   // Count register value biased towards the extremes
   function automatic logic [7:0] pick_count(int hi);
      case ($urandom_range(5))
         0:       return 8'd1;
         1:       return 8'd255;
         default: return 8'($urandom_range(hi, 1));
      endcase
   endfunction

   initial begin
      int                pick;
      int                len;
      int                session;
      logic              root;
      logic [FACE_W-1:0] src;
      logic [PAGE_W-1:0] image_pages;
      logic [CS_W-1:0]   image_cs;

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: downloader life cycle under reset defaults
      send_event(OP_PUSH, 3'd0, 8'd0, 8'd0, 16'd0);           // dropped while idle
      send_event(OP_START, 3'd0, 8'd0, 8'd0, 16'd0);
      send_event(OP_PULL, 3'd7, 8'hFF, 8'hFF, 16'hFFFF);      // face out of range
      send_event(OP_SEED, 3'd6, 8'd0, 8'd3, 16'h0001);        // first face past the last
      send_event(OP_SEED, 3'd5, 8'd0, 8'd3, 16'hFFFF);        // becomes source, pull page 0
      send_event(OP_SEED, 3'd2, 8'd0, 8'd9, 16'h1234);        // not the source
      send_event(OP_PUSH, 3'd5, 8'd1, 8'd0, 16'd0);           // out of order
      send_event(OP_PUSH, 3'd5, 8'd0, 8'd0, 16'd0);           // burn and pull next
      send_event(OP_PULL, 3'd0, 8'd0, 8'd0, 16'd0);           // serve a held page
      send_event(OP_PULL, 3'd1, 8'hFF, 8'd0, 16'd0);          // page not held yet
      send_event(OP_ACTIVE, 3'd3, 8'd0, 8'd0, 16'd0);
      send_event(OP_PUSH, 3'd5, 8'd1, 8'd0, 16'd0);
      send_event(OP_PUSH, 3'd5, 8'd2, 8'd0, 16'd0);           // last page: burn only
      send_event(OP_SEED, 3'd5, 8'd0, 8'd3, 16'hFFFF);        // complete, neighbours active
      send_event(OP_FINISHED, 3'd4, 8'd0, 8'd0, 16'd0);
      send_event(OP_LETSGO, 3'd0, 8'd0, 8'd0, 16'd0);         // not from source
      send_event(OP_LETSGO, 3'd5, 8'd0, 8'd0, 16'd0);         // storm and good exit
      send_event(OP_START, 3'd0, 8'd0, 8'd0, 16'd0);
      send_event(OP_SEED, 3'd0, 8'd0, 8'd0, 16'd0);           // empty image: finished
      send_event(OP_LETSGO, 3'd0, 8'd0, 8'd0, 16'd0);         // bad image exit

      // Directed: root with largest image, shortest countdowns; seed and full storm
      configure_node(1'b1, 8'd255, 16'hFFFF, 8'd1, 8'd1);
      send_event(OP_START, 3'd0, 8'd0, 8'd0, 16'd0);
      send_event(OP_PULL, 3'd4, 8'd254, 8'd0, 16'd0);
      send_ticks(TICKS_PER_COUNT);

      // Random sessions, idling pattern rotating per session
      session = 0;
      while (items_sent < ITEM_TARGET) begin
         root = ($urandom_range(3) == 0);
         configure_node(root, pick_count(8), CS_W'($urandom), pick_count(3), pick_count(3));
         case (session % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 78; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 78; end
            default: begin send_idle_pct = 16; stall_pct = 16; end
         endcase
         session++;

         src = FACE_W'($urandom_range(FACES - 1));
         case ($urandom_range(9))
            0:       image_pages = '0;
            1:       image_pages = PAGE_W'($urandom);
            default: image_pages = PAGE_W'($urandom_range(6, 1));
         endcase
         image_cs = CS_W'($urandom);
         send_event(OP_START, FACE_W'($urandom_range(7)), PAGE_W'($urandom),
                    PAGE_W'($urandom), CS_W'($urandom));
         items_sent++;

         len = $urandom_range(30, 10);
         for (int i = 0; i < len && flood_sb.running; i++) begin
            if (flood_sb.source_face != NO_FACE) src = flood_sb.source_face;
            pick = $urandom_range(99);
            if (!root && flood_sb.total_pages == 0 && pick < 60)
               send_event(OP_SEED, src, PAGE_W'($urandom), image_pages, image_cs);
            else if (!root && pick < 30)
               send_event(OP_PUSH, src,
                          ($urandom_range(9) == 0) ? PAGE_W'($urandom) : flood_sb.next_page,
                          PAGE_W'($urandom), CS_W'($urandom));
            else if (!root && pick < 42)
               send_event(OP_SEED, src, PAGE_W'($urandom), PAGE_W'($urandom),
                          CS_W'($urandom));
            else if (pick < 56)
               send_event(OP_PULL, FACE_W'($urandom_range(FACES - 1)),
                          (flood_sb.next_page > 0 && $urandom_range(3) != 0) ?
                             PAGE_W'($urandom_range(flood_sb.next_page - 1)) :
                             PAGE_W'($urandom),
                          PAGE_W'($urandom), CS_W'($urandom));
            else if (pick < 62)
               send_event(OP_ACTIVE, FACE_W'($urandom_range(FACES - 1)), PAGE_W'($urandom),
                          PAGE_W'($urandom), CS_W'($urandom));
            else if (pick < 66)
               send_event(OP_FINISHED, FACE_W'($urandom_range(FACES - 1)),
                          PAGE_W'($urandom), PAGE_W'($urandom), CS_W'($urandom));
            else if (pick < 76)
               send_ticks($urandom_range(6, 1));
            else if (pick < 80)
               send_ticks($urandom_range(520, 200));
            else if (pick < 88)
               send_event(OP_LETSGO,
                          (flood_sb.next_page >= flood_sb.total_pages) ?
                             src : FACE_W'($urandom_range(FACES - 1)),
                          PAGE_W'($urandom), PAGE_W'($urandom), CS_W'($urandom));
            else
               // noise: any opcode on any face, out of range ones included
               send_event(opcode_type'($urandom_range(7)), FACE_W'($urandom_range(7)),
                          PAGE_W'($urandom), PAGE_W'($urandom), CS_W'($urandom));
            items_sent++;
         end
      end

      // Drain and let the node settle before the verdict
      req_valid <= 1'b0;
      while (flood_sb.owed_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (flood_sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: sim.f
sv/fdpn_pkg.sv
sv/flood_download_protocol_node_top.sv
verif/node_check_pkg.sv
verif/tb_top.sv
